// ===== rtl/ucs_pkg.sv =====
package ucs_pkg;

    // Four bytes of a cell or of the working buffer, first byte in slot 0.
    typedef logic [3:0][7:0] byte4_t;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [7:0]  panel_index;
        logic [31:0] cell_bytes;
        logic [2:0]  byte_count;
        logic        last_cell;
    } cell_t;

    // Decision of the scan logic for the front of the working buffer.
    typedef struct packed {
        logic        can_emit;
        logic [2:0]  len;
        logic [31:0] cell_word;
        logic [2:0]  rem_cnt;
        byte4_t      rem_buf;
        logic        more;
        logic        last;
    } scan_t;

    localparam logic [7:0] PanelCountReset = 8'd7;

    localparam logic [7:0] ContMask   = 8'hC0;
    localparam logic [7:0] ContCode   = 8'h80;
    localparam logic [7:0] Lead2Mask  = 8'hE0;
    localparam logic [7:0] Lead2Code  = 8'hC0;
    localparam logic [7:0] Lead3Mask  = 8'hF0;
    localparam logic [7:0] Lead3Code  = 8'hE0;
    localparam logic [7:0] Lead4Mask  = 8'hF8;
    localparam logic [7:0] Lead4Code  = 8'hF0;

    localparam logic [20:0] Min2Byte  = 21'h80;
    localparam logic [20:0] Min3Byte  = 21'h800;
    localparam logic [20:0] SurrLow   = 21'hD800;
    localparam logic [20:0] SurrHigh  = 21'hDFFF;
    localparam logic [20:0] Min4Byte  = 21'h10000;
    localparam logic [20:0] MaxCode   = 21'h10FFFF;

    function automatic logic is_cont(input logic [7:0] b);
        return (b & ContMask) == ContCode;
    endfunction

    // Length of the cell at the front of b (n bytes present), or 0 to wait
    // for more bytes. Anything malformed gives a one-byte cell.
    function automatic logic [2:0] cell_len(input byte4_t b, input logic [2:0] n,
                                            input logic fin);
        logic [2:0]  need;
        logic [2:0]  r;
        logic        done;
        logic [20:0] cp;
        need = 3'd0;
        r    = 3'd1;
        done = 1'b0;
        cp   = '0;
        if (!b[0][7]) begin
            done = 1'b1;
        end
        else if ((b[0] & Lead2Mask) == Lead2Code) begin
            need = 3'd2;
        end
        else if ((b[0] & Lead3Mask) == Lead3Code) begin
            need = 3'd3;
        end
        else if ((b[0] & Lead4Mask) == Lead4Code) begin
            need = 3'd4;
        end
        else begin
            done = 1'b1;
        end
        // Followers in order: a missing one waits unless the text ends, a wrong one rejects.
        for (int j = 1; j < 4; j++) begin
            if (!done && j < need) begin
                if (j >= n) begin
                    done = 1'b1;
                    r    = fin ? 3'd1 : 3'd0;
                end
                else if (!is_cont(b[j])) begin
                    done = 1'b1;
                    r    = 3'd1;
                end
            end
        end
        // A complete sequence is judged by its value.
        if (!done) begin
            if (need == 3'd2) begin
                cp = {10'd0, b[0][4:0], b[1][5:0]};
                r  = (cp < Min2Byte) ? 3'd1 : 3'd2;
            end
            else if (need == 3'd3) begin
                cp = {5'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
                r  = (cp < Min3Byte || (cp >= SurrLow && cp <= SurrHigh)) ? 3'd1 : 3'd3;
            end
            else begin
                cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
                r  = (cp < Min4Byte || cp > MaxCode) ? 3'd1 : 3'd4;
            end
        end
        return r;
    endfunction

    // Drop len bytes from the front of b.
    function automatic byte4_t shift_bytes(input byte4_t b, input logic [2:0] len);
        byte4_t     o;
        logic [3:0] idx;
        for (int i = 0; i < 4; i++) begin
            idx = 4'(i) + {1'b0, len};
            o[i] = (idx < 4'd4) ? b[idx[1:0]] : 8'h00;
        end
        return o;
    endfunction

    // Keep the first len bytes, zero the rest.
    function automatic logic [31:0] pack_cell(input byte4_t b, input logic [2:0] len);
        byte4_t o;
        for (int i = 0; i < 4; i++) begin
            o[i] = (3'(i) < len) ? b[i] : 8'h00;
        end
        return o;
    endfunction

endpackage

// ===== rtl/ucs_if.sv =====
// Byte channel: one optional text byte and its end mark per item.
interface ucs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       text_end;
    modport source (output valid, data_byte, has_byte, text_end, input ready);
    modport sink   (input valid, data_byte, has_byte, text_end, output ready);
endinterface

// Cell channel: one code point cell per item.
interface ucs_cell_if;
    logic        valid;
    logic        ready;
    logic [7:0]  panel_index;
    logic [31:0] cell_bytes;
    logic [2:0]  byte_count;
    logic        last_cell;
    modport source (output valid, panel_index, cell_bytes, byte_count, last_cell,
                    input ready);
    modport sink   (input valid, panel_index, cell_bytes, byte_count, last_cell,
                    output ready);
endinterface

// Configuration write channel for the panel count.
interface ucs_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] panel_count;
    modport source (output valid, panel_count, input ready);
    modport sink   (input valid, panel_count, output ready);
endinterface

// ===== rtl/ucs_scan.sv =====
module ucs_scan (
    input  ucs_pkg::byte4_t buf_bytes,
    input  logic [2:0]      cnt,
    input  logic            fin,
    input  logic [7:0]      panels,
    input  logic [7:0]      panel_count,
    output ucs_pkg::scan_t  scan
);
    import ucs_pkg::*;

    logic       full;
    logic [2:0] len1;
    logic [2:0] len2;
    logic [7:0] panels_inc;

    always_comb begin
        // Judge the cell at the front of the buffer.
        full = panels >= panel_count;
        len1 = cell_len(buf_bytes, cnt, fin);
        scan.can_emit  = (cnt != 3'd0) && !full && (len1 != 3'd0);
        scan.len       = len1;
        scan.cell_word = pack_cell(buf_bytes, len1);
        scan.rem_cnt   = cnt - len1;
        scan.rem_buf   = shift_bytes(buf_bytes, len1);

        // Look one cell further to see whether this item goes on after this cell.
        panels_inc = panels + 8'd1;
        len2       = cell_len(scan.rem_buf, scan.rem_cnt, fin);
        scan.more  = (scan.rem_cnt != 3'd0) && (panels_inc < panel_count) && (len2 != 3'd0);
        scan.last  = fin && !scan.more;
    end

endmodule

// ===== rtl/ucs_out_stage.sv =====
module ucs_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  ucs_pkg::cell_t       load_cell,
    output logic                 free,
    ucs_cell_if.source           cell_ch
);
    import ucs_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    cell_t cell_reg;

    // The register can take a new cell when empty or being drained.
    assign free       = !valid_reg || cell_ch.ready;
    assign valid_next = free ? load : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            cell_reg <= load_cell;
        end
    end

    assign cell_ch.valid       = valid_reg;
    assign cell_ch.panel_index = cell_reg.panel_index;
    assign cell_ch.cell_bytes  = cell_reg.cell_bytes;
    assign cell_ch.byte_count  = cell_reg.byte_count;
    assign cell_ch.last_cell   = cell_reg.last_cell;

endmodule

// ===== rtl/utf8_codepoint_splitter.sv =====
// Path: an accepted byte item enters the working buffer; its cells go to the result register.
// Throughput: one item per cycle while each item yields at most one cell and the result
// register is free; an item yielding up to four cells (re-examined bytes after a broken
// sequence, or a flush) holds the input until its last cell, one cell per free cycle.
// Reset: pending bytes and the panel counter clear, the panel count returns to seven.
module utf8_codepoint_splitter (
    input  logic        clk,
    input  logic        rst_n,
    ucs_byte_if.sink    byte_ch,
    ucs_cell_if.source  cell_ch,
    ucs_cfg_if.sink     cfg
);
    import ucs_pkg::*;

    byte4_t     buf_reg;
    byte4_t     buf_next;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       fin_reg;
    logic       fin_next;
    logic       active_reg;
    logic       active_next;
    logic [7:0] panels_reg;
    logic [7:0] panels_next;
    logic [7:0] panel_count_reg;

    scan_t      scan;
    cell_t      load_cell;
    logic       out_free;
    logic       fire_cell;
    logic       fire_bare;
    logic       step_end;
    logic       take;
    byte4_t     buf_after;
    logic [2:0] cnt_after;
    logic [7:0] panels_after;

    // Configuration register; always ready.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            panel_count_reg <= PanelCountReset;
        end
        else if (cfg.valid && cfg.ready)
        begin
            panel_count_reg <= cfg.panel_count;
        end
    end

    ucs_scan u_scan (
        .buf_bytes   (buf_reg),
        .cnt         (cnt_reg),
        .fin         (fin_reg),
        .panels      (panels_reg),
        .panel_count (panel_count_reg),
        .scan        (scan)
    );

    // Emit a cell, or a bare end result when an end item yields no cell.
    always_comb begin
        fire_cell = active_reg && scan.can_emit && out_free;
        fire_bare = active_reg && !scan.can_emit && fin_reg && out_free;
        step_end  = active_reg && ((scan.can_emit && out_free && !scan.more) ||
                                   (!scan.can_emit && (!fin_reg || out_free)));
        if (fire_cell)
        begin
            load_cell.panel_index = panels_reg;
            load_cell.cell_bytes  = scan.cell_word;
            load_cell.byte_count  = scan.len;
            load_cell.last_cell   = scan.last;
        end
        else
        begin
            load_cell = '0;
            load_cell.last_cell = 1'b1;
        end
    end

    ucs_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire_cell || fire_bare),
        .load_cell (load_cell),
        .free      (out_free),
        .cell_ch   (cell_ch)
    );

    // State as this cycle leaves it, before any new item is merged.
    always_comb begin
        if (fire_cell)
        begin
            buf_after    = scan.rem_buf;
            cnt_after    = scan.rem_cnt;
            panels_after = panels_reg + 8'd1;
        end
        else
        begin
            buf_after    = buf_reg;
            cnt_after    = cnt_reg;
            panels_after = panels_reg;
        end
        if (step_end)
        begin
            if (fin_reg)
            begin
                cnt_after    = 3'd0;
                panels_after = 8'd0;
            end
            else if (panels_after >= panel_count_reg)
            begin
                cnt_after = 3'd0;
            end
        end
    end

    // A new item enters as soon as the current one finishes.
    assign byte_ch.ready = !active_reg || step_end;
    assign take          = byte_ch.valid && byte_ch.ready;

    always_comb begin
        buf_next    = buf_after;
        cnt_next    = cnt_after;
        panels_next = panels_after;
        fin_next    = fin_reg;
        active_next = active_reg && !step_end;
        if (take)
        begin
            fin_next    = byte_ch.text_end;
            active_next = byte_ch.has_byte || byte_ch.text_end;
            if (byte_ch.has_byte && panels_after < panel_count_reg)
            begin
                buf_next[cnt_after[1:0]] = byte_ch.data_byte;
                cnt_next = cnt_after + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 3'd0;
            fin_reg    <= 1'b0;
            active_reg <= 1'b0;
            panels_reg <= 8'd0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
            active_reg <= active_next;
            panels_reg <= panels_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

// ===== rtl/ucs_checker.sv =====
module ucs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  panel_index,
    input logic [31:0] cell_bytes,
    input logic [2:0]  byte_count,
    input logic        last_cell
);

    // A bare end result is empty and always closes the text.
    a_bare_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_count == 3'd0) |->
            (last_cell && cell_bytes == 32'd0 && panel_index == 8'd0))
        else $error("bare end result is not empty or not last");

    // Bytes beyond the cell length are zero; a cell holds at most four bytes.
    a_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_count <= 3'd4 &&
                       (byte_count > 3'd1 || cell_bytes[31:8] == 24'd0) &&
                       (byte_count > 3'd2 || cell_bytes[31:16] == 16'd0) &&
                       (byte_count > 3'd3 || cell_bytes[31:24] == 8'd0)))
        else $error("cell bytes beyond the count are not zero");

    // A two-byte cell is a valid, non-overlong lead with one follower.
    a_two_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && byte_count == 3'd2) |->
            (cell_bytes[7:5] == 3'b110 && cell_bytes[4:1] != 4'd0 &&
             cell_bytes[15:14] == 2'b10))
        else $error("malformed two-byte cell");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(cell_bytes) && $stable(panel_index) &&
             $stable(byte_count) && $stable(last_cell)))
        else $error("stalled result changed");

endmodule

bind utf8_codepoint_splitter ucs_checker u_ucs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (cell_ch.valid),
    .out_ready   (cell_ch.ready),
    .panel_index (cell_ch.panel_index),
    .cell_bytes  (cell_ch.cell_bytes),
    .byte_count  (cell_ch.byte_count),
    .last_cell   (cell_ch.last_cell)
);

// ===== tb/panel_cell_check.sv =====
`timescale 1ns / 1ps

// Watches the byte, cell and configuration channels of the splitter, keeps its
// own copy of the cutting state, and checks every cell against the oldest one
// still due.
module panel_cell_check (
    input  logic clk,
    input  logic rst_n,
    ucs_byte_if  byte_ch,
    ucs_cell_if  cell_ch,
    ucs_cfg_if   cfg,
    output int   bad_cells,
    output int   cells_outstanding
);
    import ucs_pkg::*;

    localparam logic [7:0]  PANELS_AT_RESET = 8'd7;
    localparam logic [20:0] TWO_BYTE_MIN    = 21'h80;
    localparam logic [20:0] THREE_BYTE_MIN  = 21'h800;
    localparam logic [20:0] SURROGATE_LO    = 21'hD800;
    localparam logic [20:0] SURROGATE_HI    = 21'hDFFF;
    localparam logic [20:0] FOUR_BYTE_MIN   = 21'h10000;
    localparam logic [20:0] CODE_POINT_MAX  = 21'h10FFFF;
    localparam int          REPORT_LIMIT    = 10;

    cell_t      cells_due[$];
    logic [7:0] held [0:2];
    int         held_cnt;
    logic [7:0] filled;
    logic [7:0] panels;
    int         mismatches = 0;

    // Length of the cell at the front of the window, or zero while a
    // plausible sequence still lacks bytes and the text has not ended.
    function automatic int code_len(input byte4_t w, input int avail, input bit fin);
        int          need;
        logic [20:0] cp;
        if (!w[0][7])
            return 1;
        if (w[0][7:5] == 3'b110)
            need = 2;
        else if (w[0][7:4] == 4'b1110)
            need = 3;
        else if (w[0][7:3] == 5'b11110)
            need = 4;
        else
            return 1;
        for (int j = 1; j < need; j++)
        begin
            if (j >= avail)
                return fin ? 1 : 0;
            if (w[j][7:6] != 2'b10)
                return 1;
        end
        case (need)
            2:
            begin
                cp = {10'd0, w[0][4:0], w[1][5:0]};
                return (cp < TWO_BYTE_MIN) ? 1 : 2;
            end
            3:
            begin
                cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
                if (cp < THREE_BYTE_MIN || (cp >= SURROGATE_LO && cp <= SURROGATE_HI))
                    return 1;
                return 3;
            end
            default:
            begin
                cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
                return (cp < FOUR_BYTE_MIN || cp > CODE_POINT_MAX) ? 1 : 4;
            end
        endcase
    endfunction

    // Cuts the held bytes plus the new byte into cells and queues them.
    task automatic split_into_cells(input logic [7:0] data, input bit has, input bit fin);
        byte4_t win;
        byte4_t rest;
        int     n;
        int     pos;
        int     len;
        int     made;
        bit     waiting;
        cell_t  c;
        cell_t  step_cells [0:3];
        win = '0;
        n = held_cnt;
        for (int i = 0; i < n; i++)
            win[i] = held[i];
        if (has && filled < panels)
        begin
            win[n] = data;
            n++;
        end
        pos = 0;
        made = 0;
        waiting = 1'b0;
        while (!waiting && pos < n && filled < panels)
        begin
            rest = win >> (8 * pos);
            len = code_len(rest, n - pos, fin);
            if (len == 0)
                waiting = 1'b1;
            else
            begin
                c.panel_index = filled;
                c.cell_bytes = 32'(rest) & 32'((64'd1 << (8 * len)) - 64'd1);
                c.byte_count = 3'(len);
                c.last_cell = 1'b0;
                step_cells[made] = c;
                made++;
                filled = filled + 8'd1;
                pos += len;
            end
        end

        // An end step always yields something: its last cell or a bare marker.
        if (fin)
        begin
            if (made == 0)
            begin
                step_cells[0] = '0;
                made = 1;
            end
            c = step_cells[made - 1];
            c.last_cell = 1'b1;
            step_cells[made - 1] = c;
            held_cnt = 0;
            filled = '0;
        end
        else if (filled >= panels)
            held_cnt = 0;
        else
        begin
            held_cnt = n - pos;
            rest = win >> (8 * pos);
            for (int i = 0; i < held_cnt && i < 3; i++)
                held[i] = rest[i];
        end
        for (int i = 0; i < made; i++)
            cells_due.push_back(step_cells[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cell_t want;
        cell_t got;
        if (!rst_n)
        begin
            cells_due.delete();
            held_cnt = 0;
            filled = '0;
            panels = PANELS_AT_RESET;
            cells_outstanding <= 0;
            bad_cells <= mismatches;
        end
        else
        begin
            // Compare an arriving cell with the oldest one due.
            if (cell_ch.valid && cell_ch.ready)
            begin
                got.panel_index = cell_ch.panel_index;
                got.cell_bytes = cell_ch.cell_bytes;
                got.byte_count = cell_ch.byte_count;
                got.last_cell = cell_ch.last_cell;
                if (cells_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: unexpected cell: panel %0d bytes %h count %0d last %b",
                                 $realtime, got.panel_index, got.cell_bytes,
                                 got.byte_count, got.last_cell);
                end
                else
                begin
                    want = cells_due.pop_front();
                    if (got.panel_index !== want.panel_index
                        || got.cell_bytes !== want.cell_bytes
                        || got.byte_count !== want.byte_count
                        || got.last_cell !== want.last_cell)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                        begin
                            $display("%0t: cell mismatch", $realtime);
                            $display("    expected panel %0d bytes %h count %0d last %b",
                                     want.panel_index, want.cell_bytes,
                                     want.byte_count, want.last_cell);
                            $display("    actual   panel %0d bytes %h count %0d last %b",
                                     got.panel_index, got.cell_bytes,
                                     got.byte_count, got.last_cell);
                        end
                    end
                end
            end

            // Track the panel count as the block sees it.
            if (cfg.valid && cfg.ready)
                panels = cfg.panel_count;

            if (byte_ch.valid && byte_ch.ready)
                split_into_cells(byte_ch.data_byte, byte_ch.has_byte, byte_ch.text_end);

            cells_outstanding <= cells_due.size();
            bad_cells <= mismatches;
        end
    end

endmodule

// ===== tb/tb_utf8_codepoint_splitter.sv =====
`timescale 1ns / 1ps

module tb_utf8_codepoint_splitter;

    typedef enum int { CLOSE_ON_BYTE, CLOSE_BARE, LEAVE_OPEN } close_t;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 9;
    localparam int RUN_LIMIT_NS = 5_000_000;
    localparam int SETTLE       = 6;

    logic       clk = 1'b0;
    logic       rst_n;
    int         bad_cells;
    int         cells_outstanding;
    int         sent_items = 0;
    bit         tx_calm = 1'b0;
    bit         rx_calm = 1'b0;
    logic [7:0] text_q[$];

    ucs_byte_if byte_ch ();
    ucs_cell_if cell_ch ();
    ucs_cfg_if  cfg_ch ();

    utf8_codepoint_splitter uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_ch (byte_ch),
        .cell_ch (cell_ch),
        .cfg     (cfg_ch)
    );

    panel_cell_check cell_check (
        .clk               (clk),
        .rst_n             (rst_n),
        .byte_ch           (byte_ch),
        .cell_ch           (cell_ch),
        .cfg               (cfg_ch),
        .bad_cells         (bad_cells),
        .cells_outstanding (cells_outstanding)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Hard stop in case the block hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Cell receiver: a random stall before each item, with calm stretches.
    initial
    begin : cell_sink
        int stall;
        cell_ch.ready = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                rx_calm = !rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                cell_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            cell_ch.ready <= 1'b1;
            do @(posedge clk); while (!cell_ch.valid);
        end
    end

    // Offers one byte item after a random gap and waits for its handshake.
    task automatic send_item(input logic [7:0] b, input bit has, input bit fin);
        int gap;
        if ($urandom_range(0, 15) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.has_byte <= has;
        byte_ch.text_end <= fin;
        do @(posedge clk); while (!byte_ch.ready);
    endtask

    // Sends the queued text, with an ignored item slipped in now and then.
    task automatic send_text(input close_t how);
        for (int i = 0; i < text_q.size(); i++)
        begin
            if ($urandom_range(0, 19) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(text_q[i], 1'b1, how == CLOSE_ON_BYTE && i == text_q.size() - 1);
            sent_items++;
        end
        if (how == CLOSE_BARE)
        begin
            send_item(8'($urandom), 1'b0, 1'b1);
            sent_items++;
        end
    endtask

    // Holds the sender until every cell due has arrived and the block is quiet.
    task automatic wait_cells_done();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (cells_outstanding != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_panels(input logic [7:0] count);
        cfg_ch.valid <= 1'b1;
        cfg_ch.panel_count <= count;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // A code point that fits the given encoded length in its shortest form.
    function automatic logic [20:0] pick_cp(input int len);
        logic [20:0] cp;
        case (len)
            1: cp = 21'($urandom_range(0, 'h7F));
            2: cp = 21'($urandom_range('h80, 'h7FF));
            3:
            begin
                cp = 21'($urandom_range('h800, 'hFFFF));
                if (cp >= 21'hD800 && cp <= 21'hDFFF)
                    cp = cp - 21'h1000;
            end
            default: cp = 21'($urandom_range('h10000, 'h10FFFF));
        endcase
        return cp;
    endfunction

    // Encodes cp in len bytes and queues the first keep of them.
    task automatic put_seq(input logic [20:0] cp, input int len, input int keep);
        logic [7:0] b [0:3];
        case (len)
            1: b[0] = {1'b0, cp[6:0]};
            2:
            begin
                b[0] = {3'b110, cp[10:6]};
                b[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                b[0] = {4'b1110, cp[15:12]};
                b[1] = {2'b10, cp[11:6]};
                b[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                b[0] = {5'b11110, cp[20:18]};
                b[1] = {2'b10, cp[17:12]};
                b[2] = {2'b10, cp[11:6]};
                b[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
            text_q.push_back(b[i]);
    endtask

    // Mostly well-formed code points; a quarter are malformed in some way.
    task automatic add_symbol();
        int         pick;
        int         len;
        logic [7:0] follower;
        pick = $urandom_range(0, 99);
        if (pick < 75)
        begin
            len = (pick < 22) ? 1 : (pick < 40) ? 2 : (pick < 58) ? 3 : 4;
            put_seq(pick_cp(len), len, len);
        end
        else
        begin
            case ($urandom_range(0, 5))
                0: text_q.push_back(8'($urandom));
                1:
                begin
                    // Truncated sequence.
                    len = $urandom_range(2, 4);
                    put_seq(pick_cp(len), len, $urandom_range(1, len - 1));
                end
                2:
                begin
                    // Overlong form.
                    len = $urandom_range(2, 4);
                    put_seq(pick_cp(len - 1), len, len);
                end
                3: put_seq(21'($urandom_range('hD800, 'hDFFF)), 3, 3);
                4: put_seq(21'($urandom_range('h110000, 'h1FFFFF)), 4, 4);
                default:
                begin
                    // Lead byte followed by something that is not a continuation.
                    follower = 8'($urandom);
                    if (follower[7:6] == 2'b10)
                        follower[6] = 1'b1;
                    text_q.push_back(8'($urandom_range('hC2, 'hF4)));
                    text_q.push_back(follower);
                end
            endcase
        end
    endtask

    initial
    begin : stimulus
        int     phase_start;
        int     quota;
        int     symbols;
        int     roll;
        close_t how;

        rst_n = 1'b0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.has_byte = 1'b0;
        byte_ch.text_end = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.panel_count = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 00/7F, least 2-byte and top 4-byte forms; a bare end marker closes.
        text_q = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        send_text(CLOSE_BARE);

        // Broken lead, surrogate, value above the limit; panels fill mid-text.
        text_q = '{8'hE2, 8'h41, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80};
        send_text(CLOSE_ON_BYTE);

        // Invalid lead, then an incomplete sequence flushed at the end.
        text_q = '{8'hFF, 8'hF0, 8'h90};
        send_text(CLOSE_ON_BYTE);

        // Empty text and an item that carries neither byte nor end.
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);

        // Panel count lowered below the cells already placed in an open text.
        text_q = '{8'h41, 8'h42, 8'h43};
        send_text(LEAVE_OPEN);
        wait_cells_done();
        set_panels(8'd2);
        text_q = '{8'h44};
        send_text(CLOSE_BARE);

        // Random texts under several panel counts, extremes included.
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_cells_done();
            case (ph)
                0: set_panels(8'd255);
                1: set_panels(8'd1);
                2: set_panels(8'd0);
                3: set_panels(8'($urandom_range(8, 254)));
                4: set_panels(8'($urandom_range(2, 6)));
                default: set_panels(8'd7);
            endcase
            quota = (ph == 2) ? 10 : 30;
            phase_start = sent_items;
            while (sent_items - phase_start < quota)
            begin
                text_q.delete();
                symbols = $urandom_range(1, 10);
                repeat (symbols) add_symbol();
                roll = $urandom_range(0, 9);
                how = (roll < 7) ? CLOSE_ON_BYTE : (roll < 9) ? CLOSE_BARE : LEAVE_OPEN;
                send_text(how);
                if ($urandom_range(0, 5) == 0)
                    wait_cells_done();
            end
        end

        // Close any text left open, then let everything drain.
        send_item(8'($urandom), 1'b0, 1'b1);
        wait_cells_done();
        repeat (20) @(posedge clk);
        if (bad_cells == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
